FILE: src/qabm_pkg.sv
// ----------------------------------------------------------------------------
// qabm_pkg
// Shared types and constants for the quote-aware brace matcher.
// ----------------------------------------------------------------------------
package qabm_pkg;

  // Deepest nesting level plus one; level MAX_LEVELS-1 is the last usable one
  localparam int MAX_LEVELS = 16;
  localparam int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(MAX_LEVELS - 1);

  // Byte codes of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  typedef enum logic [1:0] {
    ST_SCAN     = 2'd0,
    ST_MATCH    = 2'd1,
    ST_UNTERM   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Scan state, with the quote state of the current level held apart from
  // the stack of outer levels
  typedef struct packed {
    logic [LVL_W-1:0] level;
    quote_t           cur_q;
    logic             esc;
    logic             dol;
    logic             fin;
    status_t          fstat;
  } scan_state_t;

endpackage

FILE: src/qabm_core.sv
// ----------------------------------------------------------------------------
// qabm_core
// Next-state logic for one text byte: quoting, escapes, dollar-brace nesting.
// ----------------------------------------------------------------------------
module qabm_core (
  input  qabm_pkg::scan_state_t cur,
  input  qabm_pkg::quote_t      below_q,
  input  logic                  start_req,
  input  logic [7:0]            ch,
  output qabm_pkg::scan_state_t nxt,
  output logic                  push,
  output logic [1:0]            status,
  output logic [3:0]            level,
  output logic [1:0]            quote_mode
);
  import qabm_pkg::*;

  scan_state_t s;

  always_comb begin
    // A new scan starts from a clean state; stack entries above level zero
    // are always written by a push before they are read
    s = cur;
    if (start_req) begin
      s.level = '0;
      s.cur_q = Q_NONE;
      s.esc   = 1'b0;
      s.dol   = 1'b0;
      s.fin   = 1'b0;
      s.fstat = ST_SCAN;
    end

    nxt  = s;
    push = 1'b0;

    if (!s.fin) begin
      if (ch == CH_NUL) begin
        nxt.esc   = 1'b0;
        nxt.dol   = 1'b0;
        nxt.fin   = 1'b1;
        nxt.fstat = ST_UNTERM;
      end else if (s.esc) begin
        nxt.esc = 1'b0;
        nxt.dol = 1'b0;
      end else if (s.dol && ch == CH_LBRACE) begin
        nxt.dol = 1'b0;
        if (s.level == LVL_TOP) begin
          nxt.fin   = 1'b1;
          nxt.fstat = ST_OVERFLOW;
        end else begin
          nxt.level = LVL_W'(s.level + 1'b1);
          nxt.cur_q = Q_NONE;
          push      = 1'b1;
        end
      end else begin
        nxt.dol = 1'b0;
        case (ch)
          CH_DOLLAR: begin
            if (s.cur_q != Q_SINGLE) nxt.dol = 1'b1;
          end
          CH_RBRACE: begin
            if (s.cur_q == Q_NONE) begin
              if (s.level == '0) begin
                nxt.fin   = 1'b1;
                nxt.fstat = ST_MATCH;
              end else begin
                nxt.level = LVL_W'(s.level - 1'b1);
                nxt.cur_q = below_q;
              end
            end
          end
          CH_SQUOTE: begin
            if (s.cur_q != Q_DOUBLE)
              nxt.cur_q = (s.cur_q == Q_SINGLE) ? Q_NONE : Q_SINGLE;
          end
          CH_DQUOTE: begin
            if (s.cur_q != Q_SINGLE)
              nxt.cur_q = (s.cur_q == Q_DOUBLE) ? Q_NONE : Q_DOUBLE;
          end
          CH_BSLASH: begin
            if (s.cur_q != Q_SINGLE) nxt.esc = 1'b1;
          end
          default: begin
            nxt.dol = 1'b0;
          end
        endcase
      end
    end
  end

  assign status     = nxt.fin ? nxt.fstat : ST_SCAN;
  assign level      = 4'(nxt.level);
  assign quote_mode = nxt.cur_q;

endmodule

FILE: src/quote_aware_brace_matcher_unit.sv
// ----------------------------------------------------------------------------
// quote_aware_brace_matcher_unit
// Byte-serial matcher for the close brace of the outermost level, with a
// separate quote state for every dollar-brace nesting level.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------
//  input   | in_valid / in_ready | start_req, ch
//  output  | out_valid/out_ready | status, level, quote_mode
//
//  One byte a cycle unless the output stalls: the scan state and the quote
//  stack update in the cycle a transaction is accepted, and the result lands
//  in the output register. The path is the byte decode plus the read of the
//  entry below the current level.
//  Reset (rst, synchronous) clears the scan state and empties the output.
//  A stalled output holds its result; a new byte is still taken in the same
//  cycle as the held result leaves.
//
module quote_aware_brace_matcher_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       start_req,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [3:0] level,
  output logic [1:0] quote_mode
);
  import qabm_pkg::*;

  // Scan state and quote states of the outer levels
  scan_state_t      state;
  scan_state_t      state_next;
  quote_t           quote_stack [MAX_LEVELS];
  logic [LVL_W-1:0] below_idx;
  quote_t           below_q;

  logic       push;
  logic       in_acc;
  logic [1:0] status_next;
  logic [3:0] level_next;
  logic [1:0] quote_mode_next;

  // Take a byte whenever the output register is empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  // The entry just below the current level is the one a close brace restores
  assign below_idx = LVL_W'(state.level - 1'b1);
  assign below_q   = quote_stack[below_idx];

  qabm_core u_core (
    .cur        (state),
    .below_q    (below_q),
    .start_req  (start_req),
    .ch         (ch),
    .nxt        (state_next),
    .push       (push),
    .status     (status_next),
    .level      (level_next),
    .quote_mode (quote_mode_next)
  );

  // Advance the scan state on every accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state.level <= '0;
      state.cur_q <= Q_NONE;
      state.esc   <= 1'b0;
      state.dol   <= 1'b0;
      state.fin   <= 1'b0;
      state.fstat <= ST_SCAN;
    end else if (in_acc) begin
      state <= state_next;
    end
  end

  // Save the quote state of the level being left behind on a dollar-brace;
  // a start always lands at level zero, so the write index is the old level
  // only when no start is requested
  always_ff @(posedge clk) begin
    if (in_acc && push) begin
      quote_stack[start_req ? '0 : state.level] <= start_req ? Q_NONE : state.cur_q;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status     <= status_next;
      level      <= level_next;
      quote_mode <= quote_mode_next;
    end
  end

endmodule
